// ===== src/acrg_pkg.sv =====
// shared types and constants for the authenticated command replay gate
// no dependencies; used by acrg_nonce_ring and authenticated_command_replay_gate_core
package acrg_pkg;

  localparam int unsigned RING_DEPTH_DEF = 32;

  // ack codes
  localparam logic [2:0] ACK_OK       = 3'd0;
  localparam logic [2:0] ACK_BAD_TAG  = 3'd1;
  localparam logic [2:0] ACK_UNKNOWN  = 3'd2;
  localparam logic [2:0] ACK_STALE    = 3'd3;
  localparam logic [2:0] ACK_REPEAT   = 3'd4;
  localparam logic [2:0] ACK_FAULT    = 3'd5;

  // command codes
  localparam logic [7:0] CMD_ON     = 8'h01;
  localparam logic [7:0] CMD_OFF    = 8'h02;
  localparam logic [7:0] CMD_TOGGLE = 8'h03;

  // configuration register indexes
  localparam logic [1:0] CFG_SECRET_PRESENT = 2'd0;
  localparam logic [1:0] CFG_RELAY_PRESENT  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SECONDS = 2'd2;

  localparam logic [11:0] WINDOW_RESET = 12'd60;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FINISH
  } acrg_state_e;

  typedef struct packed {
    logic        length_ok;
    logic        tag_ok;
    logic [63:0] packet_nonce;
    logic [31:0] packet_time;
    logic [7:0]  command;
    logic [31:0] now_seconds;
  } acrg_item_t;

  typedef struct packed {
    logic        send_reply;
    logic [2:0]  ack_code;
    logic        relay_state;
    logic [63:0] echo_nonce;
    logic [31:0] accepted_total;
    logic [31:0] rejected_total;
  } acrg_result_t;

  // sequencer to nonce ring
  typedef struct packed {
    logic scan_start;
    logic wr_en;
  } acrg_ring_ctrl_t;

  // nonce ring to sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } acrg_ring_stat_t;

endpackage

// ===== src/acrg_nonce_ring.sv =====
// ring of recent nonces with a sequential lookup through one 64-bit comparator
// depends on acrg_pkg for the control and status structs
module acrg_nonce_ring import acrg_pkg::*; #(
  parameter int unsigned Depth = RING_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acrg_ring_ctrl_t ctrl_i,
  input  logic [63:0]     nonce_i,
  output acrg_ring_stat_t stat_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(Depth);
  localparam logic [IdxW-1:0] SlotLast = IdxW'(Depth - 1);

  logic [63:0]     mem [Depth];
  logic [Depth-1:0] valid_q, valid_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            busy_q, busy_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            hit_q, hit_d;
  logic            rd_valid_q, rd_valid_d;
  logic [63:0]     rd_data_q;
  logic [IdxW-1:0] rd_idx;
  logic            rd_go;
  logic            match;
  logic            done;

  assign rd_idx = rd_cnt_q[IdxW-1:0];
  assign rd_go  = busy_q && (rd_cnt_q != CntLast);
  // entries never written read as all ones
  assign match  = cmp_vld_q && ((rd_valid_q ? rd_data_q : '1) == nonce_i);
  assign done   = busy_q && cmp_vld_q && (rd_cnt_q == CntLast);

  assign stat_o.done = done;
  assign stat_o.hit  = hit_q | match;

  always_comb begin
    busy_d     = busy_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    hit_d      = hit_q | match;
    rd_valid_d = rd_valid_q;
    valid_d    = valid_q;
    slot_d     = slot_q;
    if (ctrl_i.scan_start) begin
      busy_d   = 1'b1;
      rd_cnt_d = '0;
      hit_d    = 1'b0;
    end else if (rd_go) begin
      rd_cnt_d   = rd_cnt_q + CntW'(1);
      cmp_vld_d  = 1'b1;
      rd_valid_d = valid_q[rd_idx];
    end else if (done) begin
      busy_d = 1'b0;
    end
    if (ctrl_i.wr_en) begin
      valid_d[slot_q] = 1'b1;
      slot_d = (slot_q == SlotLast) ? '0 : slot_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      rd_valid_q <= 1'b0;
      valid_q    <= '0;
      slot_q     <= '0;
    end else begin
      busy_q     <= busy_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      rd_valid_q <= rd_valid_d;
      valid_q    <= valid_d;
      slot_q     <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[slot_q] <= nonce_i;
    end
    if (rd_go) begin
      rd_data_q <= mem[rd_idx];
    end
  end

endmodule

// ===== src/authenticated_command_replay_gate_core.sv =====
// top level of the authenticated command replay gate: sequencer, checks, relay and totals
// depends on acrg_pkg and acrg_nonce_ring
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------------
//  command   | in        | start && !busy               | item_i (acrg_item_t)
//  result    | out       | result_valid_o, one cycle    | result_o (acrg_result_t)
//  config    | in        | cfg_valid_i && cfg_ready_o   | cfg_index_i, cfg_data_i
//
// a packet that passes length, secret, tag and time checks is looked up against the
// nonce ring one entry per cycle through a single comparator in ST_SCAN, and the result
// strobe is registered from ST_FINISH; a dropped or stale packet skips the lookup and goes
// from ST_CHECK straight to ST_FINISH; busy is high in every state but ST_IDLE
// reset clears the ring valid bits, relay bit and totals and sets config to its defaults; no clearing pass
// the result strobe cannot be stalled; config is always ready
module authenticated_command_replay_gate_core import acrg_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  acrg_item_t   item_i,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i,
  output logic         result_valid_o,
  output acrg_result_t result_o
);

  acrg_state_e     state_q, state_d;
  acrg_item_t      item_q;
  acrg_ring_ctrl_t ring_ctrl;
  acrg_ring_stat_t ring_stat;

  logic        secret_present_q;
  logic        relay_present_q;
  logic [11:0] window_seconds_q;

  logic        relay_on_q, relay_on_d;
  logic [31:0] accept_cnt_q, accept_cnt_d;
  logic [31:0] reject_cnt_q, reject_cnt_d;
  logic        stale_q, stale_d;
  logic        hit_q, hit_d;
  logic        res_vld_q, res_vld_d;
  acrg_result_t res_q, res_d;

  logic        drop;
  logic        time_ge;
  logic [31:0] skew;
  logic        record;
  logic        accepted;
  logic [2:0]  ack;

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  assign drop = !item_q.length_ok || !secret_present_q || !item_q.tag_ok;

  assign time_ge = item_q.now_seconds >= item_q.packet_time;
  assign skew    = time_ge ? (item_q.now_seconds - item_q.packet_time)
                           : (item_q.packet_time - item_q.now_seconds);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_CHECK;
      ST_CHECK:  state_d = (drop || stale_d) ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (ring_stat.done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy                 = 1'b1;
    ring_ctrl.scan_start = 1'b0;
    ring_ctrl.wr_en      = 1'b0;
    unique case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_CHECK:  ring_ctrl.scan_start = !drop && !stale_d;
      ST_SCAN:   ;
      ST_FINISH: ring_ctrl.wr_en = record;
      default:   busy = 1'b0;
    endcase
  end

  // time check and lookup outcome
  always_comb begin
    stale_d = stale_q;
    hit_d   = hit_q;
    if (state_q == ST_IDLE && start) begin
      stale_d = 1'b0;
      hit_d   = 1'b0;
    end else if (state_q == ST_CHECK) begin
      stale_d = (item_q.now_seconds == '0) || (skew > {20'd0, window_seconds_q});
    end else if (state_q == ST_SCAN && ring_stat.done) begin
      hit_d = ring_stat.hit;
    end
  end

  // decision, relay and totals
  always_comb begin
    record     = !drop && !stale_q && !hit_q;
    accepted   = 1'b0;
    relay_on_d = relay_on_q;
    ack        = ACK_OK;
    if (drop) begin
      ack = (item_q.length_ok && secret_present_q) ? ACK_BAD_TAG : ACK_OK;
    end else if (stale_q) begin
      ack = ACK_STALE;
    end else if (hit_q) begin
      ack = ACK_REPEAT;
    end else if (!relay_present_q) begin
      ack = ACK_FAULT;
    end else begin
      case (item_q.command)
        CMD_ON: begin
          relay_on_d = 1'b1;
          accepted   = 1'b1;
        end
        CMD_OFF: begin
          relay_on_d = 1'b0;
          accepted   = 1'b1;
        end
        CMD_TOGGLE: begin
          relay_on_d = !relay_on_q;
          accepted   = 1'b1;
        end
        default: ack = ACK_UNKNOWN;
      endcase
    end
    accept_cnt_d = accepted ? accept_cnt_q + 32'd1 : accept_cnt_q;
    reject_cnt_d = accepted ? reject_cnt_q : reject_cnt_q + 32'd1;

    res_d.send_reply     = !drop;
    res_d.ack_code       = ack;
    res_d.relay_state    = relay_present_q & relay_on_d;
    res_d.echo_nonce     = item_q.packet_nonce;
    res_d.accepted_total = accept_cnt_d;
    res_d.rejected_total = reject_cnt_d;
    res_vld_d            = (state_q == ST_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      secret_present_q <= 1'b0;
      relay_present_q  <= 1'b1;
      window_seconds_q <= WINDOW_RESET;
      relay_on_q       <= 1'b0;
      accept_cnt_q     <= '0;
      reject_cnt_q     <= '0;
      stale_q          <= 1'b0;
      hit_q            <= 1'b0;
      res_vld_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      stale_q   <= stale_d;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
      if (state_q == ST_FINISH) begin
        relay_on_q   <= relay_on_d;
        accept_cnt_q <= accept_cnt_d;
        reject_cnt_q <= reject_cnt_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SECRET_PRESENT: secret_present_q <= cfg_data_i[0];
          CFG_RELAY_PRESENT:  relay_present_q  <= cfg_data_i[0];
          CFG_WINDOW_SECONDS: window_seconds_q <= cfg_data_i;
          default:            ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      item_q <= item_i;
    end
    if (state_q == ST_FINISH) begin
      res_q <= res_d;
    end
  end

  acrg_nonce_ring #(
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .nonce_i (item_q.packet_nonce),
    .stat_o  (ring_stat)
  );

endmodule
